// File: rtl/serial_register_map_slave_top_macros.svh
// Assertion macros for the serial register map slave checker.
// No dependencies; included by the checker file.
`ifndef SERIAL_REGISTER_MAP_SLAVE_TOP_MACROS_SVH
`define SERIAL_REGISTER_MAP_SLAVE_TOP_MACROS_SVH

// clocked assertion, quiet while reset is held
`define SRMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion, also checked across reset
`define SRMS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/srms_pkg.sv
// Package for the serial register map slave: sizes, frame codes, sequencer states.
// No dependencies.
`default_nettype none
package srms_pkg;
    localparam int MAX_WRITE_BYTES = 64;
    localparam int DATA_WORDS      = 64;
    localparam int MAX_READ_WORDS  = 16;
    localparam int NUM_SEGMENTS    = 4;

    localparam int PAY_AW  = $clog2(MAX_WRITE_BYTES);
    localparam int DATA_AW = $clog2(DATA_WORDS);
    localparam int LIN_W   = 10;

    localparam logic [7:0] SOF_BYTE    = 8'h77;
    localparam logic [7:0] EOF_BYTE    = 8'hAA;
    localparam logic [7:0] REPLY_SOF   = 8'h66;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;
    localparam logic [7:0] STATION     = 8'h02;
    localparam logic [7:0] HI_SPECIAL  = 8'h80;
    localparam logic [7:0] LO_MODE     = 8'h00;
    localparam logic [7:0] LO_COMMIT   = 8'h01;
    localparam logic [7:0] CMD_READ    = 8'h00;
    localparam logic [7:0] CMD_WRITE   = 8'h01;

    localparam logic [2:0] REG_DEV    = 3'd0;
    localparam logic [2:0] REG_STATUS = 3'd1;
    localparam logic [2:0] REG_SEG0   = 3'd2;
    localparam logic [2:0] REG_SEG1   = 3'd3;
    localparam logic [2:0] REG_SEG2   = 3'd4;
    localparam logic [2:0] REG_SEG3   = 3'd5;

    typedef enum logic [3:0] {
        S_RX,      // taking bytes
        S_ERR,     // send checksum error byte
        S_WRD,     // read payload pair
        S_WWR,     // stage one word
        S_PRD,     // read payload bytes 0/1
        S_PUSE,    // mode or commit register
        S_CRD,     // commit sweep: read staged word
        S_CWR,     // commit sweep: write map word
        S_RHDR,    // reply header
        S_RFET,    // fetch map word
        S_RLO,
        S_RHI,
        S_RTAIL    // status, pad, checksum, trailer
    } state_t;
endpackage
`default_nettype wire

// File: rtl/serial_register_map_slave_top.sv
// Serial register map slave: frame parser, staging/commit sequencer, reply generator.
// Depends on srms_pkg.
//
// Usage:
//  s_ channel carries received bytes (s_rx_byte), one beat per byte. m_ channel carries
//  reply bytes (m_tx_byte) with m_tx_last on the final beat of a reply. cfg_ channel writes
//  device_addr(0), status_byte(1), seg_len_0..3(2..5); cfg_ready is always high and writes
//  are expected only while the block is idle.
//  Ordinary frame bytes never stall. The trailer byte starts the sequencer, which
//  holds s_ready low until done:
//   - bad checksum: one reply beat, sent once the output register is free.
//   - write: per payload word a payload RAM read, then a staging write; then in mode 0
//     a commit sweep over the staging RAM (read staged word, write map word).
//   - mode/commit register write: payload read, then register update, plus the sweep on commit.
//   - read: one beat per cycle for header and tail while m_ready takes them; per data word
//     a map RAM read, then two beats; up to 43 beats.
//  A single output register holds each reply beat; a stalled receiver (m_ready low) just
//  freezes the sequencer on the pending beat, nothing is lost.
//  Reset (aresetn low, synchronous) returns the parser to hunting for 0x77, clears the
//  config registers to defaults, the map valid bits and the staging marks; the map reads
//  zero afterwards. No clearing pass is needed.
`default_nettype none
module serial_register_map_slave_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_tx_byte,
    output logic             m_tx_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import srms_pkg::*;

    // configuration
    logic [7:0] dev_reg, status_reg;
    logic [6:0] seg_reg [NUM_SEGMENTS];

    // parser state
    state_t     state_reg, state_next;
    logic [6:0] phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] hi_reg, hi_next;
    logic [7:0] lo_reg, lo_next;
    logic [7:0] len_reg, len_next;
    logic [15:0] mode_reg, mode_next;

    // sequencer state
    logic [DATA_AW-1:0] cnt_reg, cnt_next;
    logic [LIN_W-1:0]   base_reg, base_next;
    logic [DATA_AW-1:0] words_reg, words_next;
    logic [7:0]         lenb_reg, lenb_next;
    logic [7:0]         rsum_reg, rsum_next;

    // output register
    logic       mv_reg;
    logic [7:0] mb_reg;
    logic       ml_reg;
    logic       can_load, emit, emit_last;
    logic [7:0] emit_byte;

    // memories
    logic [7:0]  pay_mem [MAX_WRITE_BYTES];
    logic [15:0] stg_mem [DATA_WORDS];
    logic [15:0] dat_mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] dv_reg;     // map word written since reset
    logic [DATA_WORDS-1:0] mark_reg;   // staged, not yet committed

    logic              pay_we;
    logic [PAY_AW-1:0] pay_wa, pay_ra0, pay_ra1;
    logic [7:0]        pay_rd0_reg, pay_rd1_reg;
    logic              stg_we;
    logic [DATA_AW-1:0] stg_wa;
    logic [15:0]       stg_rd_reg;
    logic              commit_wr;
    logic [DATA_AW-1:0] dat_ra;
    logic [15:0]       dat_rd_reg;
    logic              dat_ok_reg;

    logic              in_acc;
    logic [8:0]        pay_n, ph9;
    logic [LIN_W-1:0]  base_calc, lin_addr;
    logic              lin_ok;
    logic [6:0]        rd_words;
    logic [DATA_AW-1:0] words_m1;
    logic [15:0]       rd_word;

    assign s_ready   = (state_reg == S_RX);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign m_valid   = mv_reg;
    assign m_tx_byte = mb_reg;
    assign m_tx_last = ml_reg;
    assign can_load  = !mv_reg || m_ready;

    assign pay_n    = (cmd_reg == CMD_READ) ? 9'd0 : {1'b0, len_reg};
    assign ph9      = {2'b00, phase_reg};
    assign lin_addr = base_reg + LIN_W'(cnt_reg);
    assign lin_ok   = lin_addr < LIN_W'(DATA_WORDS);
    assign rd_words = 7'(len_reg >> 1);
    assign words_m1 = words_reg - 1'b1;
    assign rd_word  = dat_ok_reg ? dat_rd_reg : 16'h0000;

    // linear base: lengths of segments below the high address plus low address
    always_comb begin
        base_calc = LIN_W'(lo_reg);
        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            if (hi_reg > 8'(s)) begin
                base_calc = base_calc + LIN_W'(seg_reg[s]);
            end
        end
    end

    assign pay_ra0 = (state_reg == S_PRD) ? '0 : PAY_AW'({cnt_reg, 1'b0});
    assign pay_ra1 = (state_reg == S_PRD) ? PAY_AW'(1) : PAY_AW'({cnt_reg, 1'b1});
    assign stg_wa  = lin_addr[DATA_AW-1:0];
    assign dat_ra  = lin_addr[DATA_AW-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_RX: begin
                if (in_acc && phase_reg >= 7'd6 && ph9 > pay_n + 9'd7) begin
                    if (s_rx_byte == EOF_BYTE) begin
                        if (sum_reg != SUM_GOOD) begin
                            state_next = S_ERR;
                        end else if (dev_reg == STATION) begin
                            if (cmd_reg == CMD_WRITE) begin
                                if (hi_reg < HI_SPECIAL) begin
                                    if (rd_words != 7'd0) begin
                                        state_next = S_WRD;
                                    end else if (mode_reg == 16'h0000) begin
                                        state_next = S_CRD;
                                    end
                                end else if (hi_reg == HI_SPECIAL &&
                                             (lo_reg == LO_MODE || lo_reg == LO_COMMIT)) begin
                                    state_next = S_PRD;
                                end
                            end else if (cmd_reg == CMD_READ) begin
                                state_next = S_RHDR;
                            end
                        end
                    end
                end
            end
            S_ERR:  if (can_load) state_next = S_RX;
            S_WRD:  state_next = S_WWR;
            S_WWR: begin
                if (cnt_reg == words_m1) begin
                    state_next = (mode_reg == 16'h0000) ? S_CRD : S_RX;
                end else begin
                    state_next = S_WRD;
                end
            end
            S_PRD:  state_next = S_PUSE;
            S_PUSE: begin
                if (lo_reg == LO_COMMIT && pay_rd0_reg != 8'h00) state_next = S_CRD;
                else state_next = S_RX;
            end
            S_CRD:  state_next = S_CWR;
            S_CWR:  state_next = (cnt_reg == DATA_AW'(DATA_WORDS - 1)) ? S_RX : S_CRD;
            S_RHDR: begin
                if (can_load && cnt_reg == DATA_AW'(5)) begin
                    state_next = (words_reg == '0) ? S_RTAIL : S_RFET;
                end
            end
            S_RFET: state_next = S_RLO;
            S_RLO:  if (can_load) state_next = S_RHI;
            S_RHI: begin
                if (can_load) state_next = (cnt_reg == words_m1) ? S_RTAIL : S_RFET;
            end
            S_RTAIL: if (can_load && cnt_reg == DATA_AW'(4)) state_next = S_RX;
            default: state_next = S_RX;
        endcase
    end

    // datapath controls and register next values
    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        cmd_next   = cmd_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        len_next   = len_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        words_next = words_reg;
        lenb_next  = lenb_reg;
        rsum_next  = rsum_reg;
        pay_we     = 1'b0;
        pay_wa     = PAY_AW'(phase_reg - 7'd6);
        stg_we     = 1'b0;
        commit_wr  = 1'b0;
        emit       = 1'b0;
        emit_byte  = 8'h00;
        emit_last  = 1'b0;
        unique case (state_reg)
            S_RX: begin
                if (in_acc) begin
                    unique case (phase_reg)
                        7'd0: if (s_rx_byte == SOF_BYTE) phase_next = 7'd1;
                        7'd1: begin
                            cmd_next = s_rx_byte;
                            sum_next = sum_reg + s_rx_byte;
                            phase_next = 7'd2;
                        end
                        7'd2: begin
                            if (s_rx_byte == STATION) begin
                                sum_next = sum_reg + s_rx_byte;
                                phase_next = 7'd3;
                            end else begin
                                sum_next = 8'h00;
                                phase_next = 7'd0;
                            end
                        end
                        7'd3: begin
                            lo_next = s_rx_byte;
                            sum_next = sum_reg + s_rx_byte;
                            phase_next = 7'd4;
                        end
                        7'd4: begin
                            hi_next = s_rx_byte;
                            sum_next = sum_reg + s_rx_byte;
                            phase_next = 7'd5;
                        end
                        7'd5: begin
                            len_next = s_rx_byte;
                            if (cmd_reg != CMD_READ && s_rx_byte > 8'(MAX_WRITE_BYTES)) begin
                                sum_next = 8'h00;
                                phase_next = 7'd0;
                            end else begin
                                sum_next = sum_reg + s_rx_byte;
                                phase_next = 7'd6;
                            end
                        end
                        default: begin
                            if (ph9 < pay_n + 9'd6) begin
                                pay_we = (phase_reg - 7'd6) < 7'(MAX_WRITE_BYTES);
                                sum_next = sum_reg + s_rx_byte;
                                phase_next = phase_reg + 7'd1;
                            end else if (ph9 < pay_n + 9'd8) begin
                                sum_next = sum_reg + s_rx_byte;
                                phase_next = phase_reg + 7'd1;
                            end else begin
                                // trailer: latch what the sequencer needs
                                sum_next   = 8'h00;
                                phase_next = 7'd0;
                                rsum_next  = (sum_reg != SUM_GOOD) ? sum_reg : 8'h00;
                                cnt_next   = '0;
                                base_next  = base_calc;
                                if (cmd_reg == CMD_READ) begin
                                    if (rd_words > 7'(MAX_READ_WORDS)) begin
                                        words_next = DATA_AW'(MAX_READ_WORDS);
                                        lenb_next  = 8'(MAX_READ_WORDS * 2);
                                    end else begin
                                        words_next = DATA_AW'(rd_words);
                                        lenb_next  = len_reg;
                                    end
                                end else begin
                                    words_next = DATA_AW'(rd_words);
                                    lenb_next  = len_reg;
                                end
                            end
                        end
                    endcase
                end
            end
            S_ERR: begin
                emit = can_load;
                emit_byte = rsum_reg;
                emit_last = 1'b1;
            end
            S_WRD: ;
            S_WWR: begin
                stg_we = lin_ok;
                cnt_next = (cnt_reg == words_m1) ? '0 : cnt_reg + 1'b1;
            end
            S_PRD: ;
            S_PUSE: begin
                cnt_next = '0;
                if (lo_reg == LO_MODE) mode_next = {pay_rd1_reg, pay_rd0_reg};
            end
            S_CRD: ;
            S_CWR: begin
                commit_wr = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_RHDR: begin
                emit = can_load;
                case (cnt_reg)
                    DATA_AW'(0): emit_byte = REPLY_SOF;
                    DATA_AW'(1): emit_byte = 8'h00;
                    DATA_AW'(2): emit_byte = dev_reg;
                    DATA_AW'(3): emit_byte = lo_reg;
                    DATA_AW'(4): emit_byte = hi_reg;
                    default:     emit_byte = lenb_reg;
                endcase
                if (can_load) begin
                    if (cnt_reg != '0) rsum_next = rsum_reg + emit_byte;
                    cnt_next = (cnt_reg == DATA_AW'(5)) ? '0 : cnt_reg + 1'b1;
                end
            end
            S_RFET: ;
            S_RLO: begin
                emit = can_load;
                emit_byte = rd_word[7:0];
                if (can_load) rsum_next = rsum_reg + emit_byte;
            end
            S_RHI: begin
                emit = can_load;
                emit_byte = rd_word[15:8];
                if (can_load) begin
                    rsum_next = rsum_reg + emit_byte;
                    cnt_next = (cnt_reg == words_m1) ? '0 : cnt_reg + 1'b1;
                end
            end
            S_RTAIL: begin
                emit = can_load;
                case (cnt_reg)
                    DATA_AW'(0): emit_byte = status_reg;
                    DATA_AW'(3): emit_byte = ~rsum_reg;
                    DATA_AW'(4): emit_byte = EOF_BYTE;
                    default:     emit_byte = 8'h00;
                endcase
                emit_last = (cnt_reg == DATA_AW'(4));
                if (can_load) begin
                    if (cnt_reg < DATA_AW'(3)) rsum_next = rsum_reg + emit_byte;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_RX;
            phase_reg  <= '0;
            sum_reg    <= '0;
            cmd_reg    <= '0;
            hi_reg     <= '0;
            lo_reg     <= '0;
            len_reg    <= '0;
            mode_reg   <= '0;
            cnt_reg    <= '0;
            base_reg   <= '0;
            words_reg  <= '0;
            lenb_reg   <= '0;
            rsum_reg   <= '0;
            mv_reg     <= 1'b0;
            dev_reg    <= STATION;
            status_reg <= '0;
            for (int s = 0; s < NUM_SEGMENTS; s++) seg_reg[s] <= '0;
            dv_reg     <= '0;
            mark_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            len_reg   <= len_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            words_reg <= words_next;
            lenb_reg  <= lenb_next;
            rsum_reg  <= rsum_next;
            if (emit) begin
                mv_reg <= 1'b1;
                mb_reg <= emit_byte;
                ml_reg <= emit_last;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_DEV:    dev_reg    <= cfg_data;
                    REG_STATUS: status_reg <= cfg_data;
                    REG_SEG0:   seg_reg[0] <= cfg_data[6:0];
                    REG_SEG1:   seg_reg[1] <= cfg_data[6:0];
                    REG_SEG2:   seg_reg[2] <= cfg_data[6:0];
                    REG_SEG3:   seg_reg[3] <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (stg_we) mark_reg[stg_wa] <= 1'b1;
            if (commit_wr) begin
                mark_reg[cnt_reg] <= 1'b0;
                if (mark_reg[cnt_reg]) dv_reg[cnt_reg] <= 1'b1;
            end
        end
    end

    // payload RAM: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (pay_we) pay_mem[pay_wa] <= s_rx_byte;
        pay_rd0_reg <= pay_mem[pay_ra0];
        pay_rd1_reg <= pay_mem[pay_ra1];
    end

    // staging RAM
    always_ff @(posedge aclk) begin
        if (stg_we) stg_mem[stg_wa] <= {pay_rd1_reg, pay_rd0_reg};
        stg_rd_reg <= stg_mem[cnt_reg];
    end

    // map RAM; dv_reg masks never-written words to zero
    always_ff @(posedge aclk) begin
        if (commit_wr && mark_reg[cnt_reg]) dat_mem[cnt_reg] <= stg_rd_reg;
        dat_rd_reg <= dat_mem[dat_ra];
        dat_ok_reg <= lin_ok && dv_reg[dat_ra];
    end
endmodule
`default_nettype wire

// File: rtl/srms_checker.sv
// Port-level checker for the serial register map slave, bound to the top level.
// Depends on serial_register_map_slave_top_macros.svh.
`default_nettype none
`include "serial_register_map_slave_top_macros.svh"
module srms_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_tx_byte,
    input wire logic       m_tx_last
);
    `SRMS_ASSERT(a_m_hold, m_valid && !m_ready |=> m_valid, "reply beat dropped while stalled")
    `SRMS_ASSERT(a_m_stable, m_valid && !m_ready |=> $stable(m_tx_byte) && $stable(m_tx_last), "stalled beat changed")
    `SRMS_ASSERT(a_busy_mid_reply, m_valid && !m_tx_last |-> !s_ready, "rx taken mid reply")
    `SRMS_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid, "reply beat after reset")
endmodule

bind serial_register_map_slave_top srms_checker u_srms_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_tx_byte (m_tx_byte),
    .m_tx_last (m_tx_last)
);
`default_nettype wire

// File: tb/serial_register_map_slave_top_test.sv
// Self-checking testbench for serial_register_map_slave_top: byte frames in, reply beats out.
// Depends on srms_pkg and the RTL top; holds its own frame parser and register map model.
`default_nettype none
module serial_register_map_slave_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import srms_pkg::*;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } reply_beat_t;

    // one directed frame: header fields, payload seed, wanted byte sum, trailer
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] stn;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] len;
        logic [7:0] pfill;
        logic [7:0] sum_to;
        logic [7:0] trl;
    } frame_row_t;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 400;   // room for a commit sweep, which sends no reply
    localparam int  RANDOM_BEATS   = 16;    // per setting, five settings

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_tx_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = REG_DEV;
    logic [7:0] cfg_data = 8'h00;

    serial_register_map_slave_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_tx_byte(m_tx_byte), .m_tx_last(m_tx_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Shadow of the block: config, parser state, map, staging
    // ---------------------------------------------------------------------
    logic [7:0]  own_addr;
    logic [7:0]  sw_status;
    logic [6:0]  seg_words [NUM_SEGMENTS];
    int          parse_pos;
    logic [7:0]  byte_sum;
    logic [7:0]  frame_cmd, frame_hi, frame_lo, frame_len;
    logic [7:0]  pay_bytes [MAX_WRITE_BYTES];
    logic [15:0] commit_sel;
    logic [15:0] map_words [DATA_WORDS];
    logic [15:0] stage_words [DATA_WORDS];
    bit          stage_mark [DATA_WORDS];

    reply_beat_t reply_q[$];     // expected reply beats, oldest first

    int  mismatches = 0;
    int  beats_in = 0, beats_out = 0, frames_sent = 0, replies_seen = 0;
    int  sender_idle = 0, receiver_idle = 0;
    int  quiet_cycles = 0;

    function automatic int map_base();
        int acc;
        acc = 0;
        for (int s = 0; s < NUM_SEGMENTS && s < frame_hi; s++) acc += seg_words[s];
        return acc + frame_lo;
    endfunction

    function automatic void commit_staged();
        for (int i = 0; i < DATA_WORDS; i++) begin
            if (stage_mark[i]) map_words[i] = stage_words[i];
            stage_mark[i] = 0;
        end
    endfunction

    function automatic void build_read_reply();
        logic [7:0] rb [MAX_READ_WORDS*2 + 11];
        int         nw, base, n;
        logic [7:0] lenb, csum;
        logic [15:0] w;
        nw   = frame_len >> 1;
        base = map_base();
        lenb = frame_len;
        csum = 8'h00;
        if (nw > MAX_READ_WORDS) begin
            nw   = MAX_READ_WORDS;
            lenb = 8'(MAX_READ_WORDS * 2);
        end
        rb[0] = REPLY_SOF; rb[1] = 8'h00; rb[2] = own_addr;
        rb[3] = frame_lo;  rb[4] = frame_hi; rb[5] = lenb;
        for (int i = 0; i < nw; i++) begin
            w = (base + i < DATA_WORDS) ? map_words[base + i] : 16'h0000;
            rb[6 + 2*i] = w[7:0];
            rb[7 + 2*i] = w[15:8];
        end
        n = 6 + 2*nw;
        rb[n] = sw_status; rb[n+1] = 8'h00; rb[n+2] = 8'h00;
        for (int i = 1; i < n + 3; i++) csum += rb[i];
        rb[n+3] = ~csum;
        rb[n+4] = EOF_BYTE;
        for (int i = 0; i < n + 5; i++) reply_q.push_back('{rb[i], i == n + 4});
    endfunction

    function automatic void apply_write();
        int base;
        if (frame_hi < HI_SPECIAL) begin
            base = map_base();
            for (int i = 0; i < (frame_len >> 1); i++) begin
                if (base + i < DATA_WORDS) begin
                    stage_words[base + i] = {pay_bytes[2*i+1], pay_bytes[2*i]};
                    stage_mark[base + i]  = 1;
                end
            end
            if (commit_sel == 16'h0000) commit_staged();
        end else if (frame_hi == HI_SPECIAL && frame_lo == LO_MODE) begin
            commit_sel = {pay_bytes[1], pay_bytes[0]};
        end else if (frame_hi == HI_SPECIAL && frame_lo == LO_COMMIT && pay_bytes[0] != 0) begin
            commit_staged();
        end
    endfunction

    // advance the shadow parser by one received byte
    function automatic void parse_rx_byte(input logic [7:0] b);
        int plen;
        case (parse_pos)
            0: if (b == SOF_BYTE) parse_pos = 1;
            1: begin frame_cmd = b; byte_sum += b; parse_pos = 2; end
            2: if (b == STATION) begin
                    byte_sum += b; parse_pos = 3;
                end else begin
                    byte_sum = 0; parse_pos = 0;   // wrong station byte
                end
            3: begin frame_lo = b; byte_sum += b; parse_pos = 4; end
            4: begin frame_hi = b; byte_sum += b; parse_pos = 5; end
            5: begin
                frame_len = b;
                if (frame_cmd != CMD_READ && b > MAX_WRITE_BYTES) begin
                    byte_sum = 0; parse_pos = 0;   // over-long write
                end else begin
                    byte_sum += b; parse_pos = 6;
                end
            end
            default: begin
                plen = (frame_cmd == CMD_READ) ? 0 : frame_len;
                if (parse_pos < 6 + plen) begin
                    if (parse_pos - 6 < MAX_WRITE_BYTES) pay_bytes[parse_pos - 6] = b;
                    byte_sum += b; parse_pos++;
                end else if (parse_pos <= 7 + plen) begin
                    byte_sum += b; parse_pos++;
                end else begin
                    if (b == EOF_BYTE) begin
                        if (byte_sum != SUM_GOOD) reply_q.push_back('{byte_sum, 1'b1});
                        else if (own_addr == STATION) begin
                            if (frame_cmd == CMD_WRITE) apply_write();
                            else if (frame_cmd == CMD_READ) build_read_reply();
                        end
                    end
                    byte_sum = 0; parse_pos = 0;
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Reply checker and receiver stalls
    // ---------------------------------------------------------------------
    always @(negedge aclk) m_ready = ($urandom_range(99) >= receiver_idle);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reply_beat_t want;
            beats_out++;
            if (m_tx_last) replies_seen++;
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply beat tx=%02h last=%0b", m_tx_byte, m_tx_last);
            end else begin
                want = reply_q.pop_front();
                if (want.tx !== m_tx_byte || want.last !== m_tx_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply beat %0d: expected tx=%02h last=%0b, got tx=%02h last=%0b",
                                 beats_out, want.tx, want.last, m_tx_byte, m_tx_last);
                end
            end
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers: inputs change on the falling edge
    // ---------------------------------------------------------------------
    task automatic send_rx_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        parse_rx_byte(b);
        beats_in++;
    endtask

    task automatic release_rx();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DEV:    own_addr  = val;
            REG_STATUS: sw_status = val;
            default:    seg_words[idx - REG_SEG0] = val[6:0];
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // block idle: every reply in, then room for a trailing commit sweep
    task automatic wait_idle();
        release_rx();
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // frame with the checksum byte chosen so the command..checksum sum lands on sum_to
    task automatic send_frame(input frame_row_t r, input bit rnd_pay);
        logic [7:0] pay [$];
        logic [7:0] s, errb;
        int         plen;
        plen = (r.cmd == CMD_READ) ? 0 : r.len;
        errb = rnd_pay ? 8'($urandom) : 8'h00;
        for (int i = 0; i < plen; i++) pay.push_back(rnd_pay ? 8'($urandom) : (r.pfill ^ 8'(i)));
        s = r.cmd + r.stn + r.lo + r.hi + r.len + errb;
        foreach (pay[i]) s += pay[i];
        send_rx_byte(SOF_BYTE);
        send_rx_byte(r.cmd);
        send_rx_byte(r.stn);
        if (r.stn == STATION) begin
            send_rx_byte(r.lo);
            send_rx_byte(r.hi);
            send_rx_byte(r.len);
            // over-long write ends at the length byte
            if (plen <= MAX_WRITE_BYTES) begin
                foreach (pay[i]) send_rx_byte(pay[i]);
                send_rx_byte(errb);
                send_rx_byte(r.sum_to - s);
                send_rx_byte(r.trl);
            end
        end
        frames_sent++;
    endtask

    // mostly well-formed frames with random content, some broken ones and line noise
    task automatic send_random_frame();
        frame_row_t r;
        int         pick;
        pick     = $urandom_range(99);
        r.cmd    = (pick < 47) ? CMD_READ : (pick < 94) ? CMD_WRITE : 8'($urandom);
        r.stn    = ($urandom_range(19) == 0) ? 8'($urandom) : STATION;
        r.lo     = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        r.hi     = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
        r.len    = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(24));
        r.pfill  = 8'h00;
        r.sum_to = ($urandom_range(9) == 0) ? 8'($urandom) : SUM_GOOD;
        r.trl    = ($urandom_range(19) == 0) ? 8'($urandom) : EOF_BYTE;
        if (r.cmd == CMD_WRITE && $urandom_range(5) == 0) begin
            r.hi  = HI_SPECIAL;
            r.lo  = 8'($urandom_range(1));
            r.len = 8'($urandom_range(2, 4));
        end
        if (r.cmd == CMD_WRITE && $urandom_range(14) == 0) r.len = 8'(MAX_WRITE_BYTES);
        send_frame(r, 1'b1);
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom));
    endtask

    task automatic apply_setting(input int k);
        case (k)
            0: begin
                write_reg(REG_DEV, STATION);  write_reg(REG_STATUS, 8'h5A);
                write_reg(REG_SEG0, 8'd3);    write_reg(REG_SEG1, 8'd64);
                write_reg(REG_SEG2, 8'd0);    write_reg(REG_SEG3, 8'd10);
            end
            1: begin   // station mismatch: good frames do nothing
                write_reg(REG_DEV, 8'h00);    write_reg(REG_STATUS, 8'hFF);
            end
            2: begin
                write_reg(REG_DEV, STATION);  write_reg(REG_STATUS, 8'h00);
                write_reg(REG_SEG0, 8'd0);    write_reg(REG_SEG1, 8'd0);
                write_reg(REG_SEG2, 8'd64);   write_reg(REG_SEG3, 8'd64);
            end
            3: write_reg(REG_DEV, 8'hFF);
            default: begin
                write_reg(REG_DEV, STATION);  write_reg(REG_STATUS, 8'($urandom));
                write_reg(REG_SEG0, 8'($urandom_range(20)));
                write_reg(REG_SEG1, 8'($urandom_range(20)));
                write_reg(REG_SEG2, 8'($urandom_range(64)));
                write_reg(REG_SEG3, 8'($urandom_range(64)));
            end
        endcase
    endtask

    // directed frames; a bad-checksum row expects its own sum_to back as one beat
    frame_row_t directed_rows [] = '{
        '{CMD_WRITE, STATION, 8'h00, 8'h00, 8'd4,   8'h12, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h00, 8'h00, 8'd4,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'hFF, 8'h00, 8'd2,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, LO_MODE, HI_SPECIAL, 8'd2, 8'h01, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, 8'h02, 8'h01, 8'd6,   8'hFF, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h02, 8'h01, 8'd6,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, LO_COMMIT, HI_SPECIAL, 8'd2, 8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, LO_COMMIT, HI_SPECIAL, 8'd2, 8'h80, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h02, 8'h01, 8'd6,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, LO_MODE, HI_SPECIAL, 8'd2, 8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h00, 8'h00, 8'd255, 8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h00, 8'h00, 8'd3,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, 8'h00, 8'h00, 8'd65,  8'h33, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, 8'h00, 8'h03, 8'd8,   8'h5A, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, 8'd50, 8'h00, 8'd32,  8'hA5, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'd40, 8'h00, 8'd48,  8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  8'h03,   8'h00, 8'h00, 8'd2,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h00, 8'h00, 8'd2,   8'h00, SUM_GOOD, 8'h55},
        '{CMD_READ,  STATION, 8'h00, 8'h00, 8'd2,   8'h00, 8'h00,    EOF_BYTE},
        '{CMD_WRITE, STATION, 8'h01, 8'h00, 8'd2,   8'h00, 8'hFE,    EOF_BYTE},
        '{8'h07,     STATION, 8'h00, 8'h00, 8'd2,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, 8'd10, 8'h00, 8'd5,   8'hC3, SUM_GOOD, EOF_BYTE},
        '{CMD_WRITE, STATION, 8'h00, 8'h81, 8'd2,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h00, 8'h00, 8'd0,   8'h00, SUM_GOOD, EOF_BYTE},
        '{CMD_READ,  STATION, 8'h00, 8'hFF, 8'd32,  8'h00, SUM_GOOD, EOF_BYTE}
    };

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int typed_depth;
        own_addr   = STATION;
        sw_status  = 8'h00;
        parse_pos  = 0;
        byte_sum   = 8'h00;
        frame_cmd  = 8'h00; frame_hi = 8'h00; frame_lo = 8'h00; frame_len = 8'h00;
        commit_sel = 16'h0000;
        for (int i = 0; i < NUM_SEGMENTS; i++) seg_words[i] = 7'd0;
        for (int i = 0; i < DATA_WORDS; i++) begin
            map_words[i] = 16'h0000; stage_words[i] = 16'h0000; stage_mark[i] = 0;
        end
        for (int i = 0; i < MAX_WRITE_BYTES; i++) pay_bytes[i] = 8'h00;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // a fresh map reads zero before any config is touched
        send_frame('{CMD_READ, STATION, 8'h00, 8'h00, 8'd8, 8'h00, SUM_GOOD, EOF_BYTE}, 1'b0);
        wait_idle();

        for (int k = 0; k < 5; k++) begin
            sender_idle   = (k < 2) ? 11 : (k < 4) ? 85 : 0;
            receiver_idle = (k < 2) ? 85 : (k < 4) ? 11 : 0;
            apply_setting(k);
            if (k == 0) begin
                foreach (directed_rows[j]) begin
                    send_frame(directed_rows[j], 1'b0);
                    // checksum error reply: the newest beat is the typed-in value
                    if (directed_rows[j].sum_to != SUM_GOOD &&
                        directed_rows[j].stn == STATION &&
                        directed_rows[j].trl == EOF_BYTE) begin
                        void'(reply_q.pop_back());
                        reply_q.push_back('{directed_rows[j].sum_to, 1'b1});
                    end
                end
            end
            typed_depth = beats_in;
            while (beats_in - typed_depth < RANDOM_BEATS) begin
                send_random_frame();
                // now and then hold off until every reply is back
                if ($urandom_range(15) == 0) begin
                    release_rx();
                    while (reply_q.size() != 0) @(posedge aclk);
                end
            end
            wait_idle();
        end

        $display("covered %0d frames, %0d rx beats, %0d replies (%0d tx beats) over 5 settings",
                 frames_sent, beats_in, replies_seen, beats_out);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatching reply beats", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: serial_register_map_slave_top.f
+incdir+rtl
rtl/srms_pkg.sv
rtl/serial_register_map_slave_top.sv
rtl/srms_checker.sv
tb/serial_register_map_slave_top_test.sv
